### hw/rtl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants for the site pattern compressor
// Transaction payloads, command and status codes, and the controller to
// datapath operation codes and status bundle.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int MAX_TAXA      = 64;
  localparam int MAX_SITES     = 1024;
  localparam int ALPHABET_SIZE = 256;

  localparam int ROW_W  = $clog2(MAX_TAXA);       // taxon row index
  localparam int COL_W  = $clog2(MAX_SITES);      // site column index
  localparam int CHR_W  = $clog2(ALPHABET_SIZE);  // character / code
  localparam int TCNT_W = ROW_W + 1;              // taxon count
  localparam int SCNT_W = COL_W + 1;              // site count, weights
  localparam int IDX_W  = COL_W + 2;              // merge sort bounds

  typedef enum logic [1:0] {
    CMD_MAP_WR   = 2'd0,
    CMD_SYM_WR   = 2'd1,
    CMD_COMPRESS = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TAXA  = 2'd1;
  localparam logic [1:0] STATUS_MAP_ZERO = 2'd2;

  // configuration register indexes (byte address 4*index)
  localparam logic REG_TAXON_COUNT = 1'b0;
  localparam logic REG_SITE_COUNT  = 1'b1;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  map_character;
    logic [31:0] state_value;
    logic [5:0]  taxon_index;
    logic [9:0]  site_index;
    logic [7:0]  symbol;
  } asp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] unique_count;
    logic [7:0]  read_symbol;
    logic [10:0] pattern_weight;
  } asp_rsp_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_MAP_WR, OP_SYM_WR, OP_RD_ISSUE, OP_RD_DONE,
    OP_C_START, OP_C_CHK, OP_MX_RD, OP_MX_EV,
    OP_B_RD, OP_B_LD, OP_B_SRD, OP_B_SEV, OP_B_ADV,
    OP_E_RD, OP_E_CODE, OP_E_WR,
    OP_S_PASS, OP_S_BLK, OP_S_RD, OP_S_DEC, OP_S_TAKE,
    OP_CMP_RD, OP_CMP_EV,
    OP_U_RD, OP_U_DEC, OP_U_MRG,
    OP_W_RD, OP_W_COL, OP_W_CRD, OP_W_CODE, OP_W_WR,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic chk_stop;
    logic idx_last;
    logic b_search;
    logic b_jeq;
    logic b_match;
    logic e_last;
    logic s_wdone;
    logic s_lodone;
    logic s_both;
    logic s_none;
    logic cmp_done;
    logic u_end;
    logic u_first;
    logic w_end;
    logic r_last;
  } dp_status_t;

endpackage

### hw/rtl/asp_ctrl.sv
// ----------------------------------------------------------------------------
// asp_ctrl: compressor sequencer
// Walks the check, code build, encode, merge sort, merge and write back
// phases, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module asp_ctrl import asp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       command,
  input  dp_status_t stat,
  output dp_op_t     op,
  output logic       busy
);

  typedef enum logic [30:0] {
    CS_IDLE    = 31'd1 << 0,
    CS_RD_DONE = 31'd1 << 1,
    CS_C_CHK   = 31'd1 << 2,
    CS_MX_RD   = 31'd1 << 3,
    CS_MX_EV   = 31'd1 << 4,
    CS_B_RD    = 31'd1 << 5,
    CS_B_LD    = 31'd1 << 6,
    CS_B_SRD   = 31'd1 << 7,
    CS_B_SEV   = 31'd1 << 8,
    CS_B_ADV   = 31'd1 << 9,
    CS_E_RD    = 31'd1 << 10,
    CS_E_CODE  = 31'd1 << 11,
    CS_E_WR    = 31'd1 << 12,
    CS_S_PASS  = 31'd1 << 13,
    CS_S_BLK   = 31'd1 << 14,
    CS_S_RD    = 31'd1 << 15,
    CS_S_DEC   = 31'd1 << 16,
    CS_SC_RD   = 31'd1 << 17,
    CS_SC_EV   = 31'd1 << 18,
    CS_S_TAKE  = 31'd1 << 19,
    CS_U_RD    = 31'd1 << 20,
    CS_U_DEC   = 31'd1 << 21,
    CS_UC_RD   = 31'd1 << 22,
    CS_UC_EV   = 31'd1 << 23,
    CS_U_MRG   = 31'd1 << 24,
    CS_W_RD    = 31'd1 << 25,
    CS_W_COL   = 31'd1 << 26,
    CS_W_CRD   = 31'd1 << 27,
    CS_W_CODE  = 31'd1 << 28,
    CS_W_WR    = 31'd1 << 29,
    CS_FIN     = 31'd1 << 30
  } cstate_t;

  cstate_t state, state_next;

  assign busy = (state != CS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NOP;
    case (state)
      CS_IDLE: begin
        if (start) begin
          case (command)
            CMD_MAP_WR:   op = OP_MAP_WR;
            CMD_SYM_WR:   op = OP_SYM_WR;
            CMD_READ: begin
              op         = OP_RD_ISSUE;
              state_next = CS_RD_DONE;
            end
            CMD_COMPRESS: begin
              op         = OP_C_START;
              state_next = CS_C_CHK;
            end
            default:      op = OP_NOP;
          endcase
        end
      end
      CS_RD_DONE: begin
        op         = OP_RD_DONE;
        state_next = CS_IDLE;
      end
      CS_C_CHK: begin
        op         = OP_C_CHK;
        state_next = stat.chk_stop ? CS_IDLE : CS_MX_RD;
      end
      CS_MX_RD: begin
        op         = OP_MX_RD;
        state_next = CS_MX_EV;
      end
      CS_MX_EV: begin
        op         = OP_MX_EV;
        state_next = stat.idx_last ? CS_B_RD : CS_MX_RD;
      end
      CS_B_RD: begin
        op         = OP_B_RD;
        state_next = CS_B_LD;
      end
      CS_B_LD: begin
        op         = OP_B_LD;
        state_next = stat.b_search ? CS_B_SRD : CS_B_ADV;
      end
      CS_B_SRD: begin
        op         = OP_B_SRD;
        state_next = stat.b_jeq ? CS_B_ADV : CS_B_SEV;
      end
      CS_B_SEV: begin
        op         = OP_B_SEV;
        state_next = stat.b_match ? CS_B_ADV : CS_B_SRD;
      end
      CS_B_ADV: begin
        op         = OP_B_ADV;
        state_next = stat.idx_last ? CS_E_RD : CS_B_RD;
      end
      CS_E_RD: begin
        op         = OP_E_RD;
        state_next = CS_E_CODE;
      end
      CS_E_CODE: begin
        op         = OP_E_CODE;
        state_next = CS_E_WR;
      end
      CS_E_WR: begin
        op         = OP_E_WR;
        state_next = stat.e_last ? CS_S_PASS : CS_E_RD;
      end
      CS_S_PASS: begin
        op         = OP_S_PASS;
        state_next = stat.s_wdone ? CS_U_RD : CS_S_BLK;
      end
      CS_S_BLK: begin
        op         = OP_S_BLK;
        state_next = stat.s_lodone ? CS_S_PASS : CS_S_RD;
      end
      CS_S_RD: begin
        op         = OP_S_RD;
        state_next = CS_S_DEC;
      end
      CS_S_DEC: begin
        op = OP_S_DEC;
        if (stat.s_both) begin
          state_next = CS_SC_RD;
        end else if (stat.s_none) begin
          state_next = CS_S_BLK;
        end else begin
          state_next = CS_S_RD;
        end
      end
      CS_SC_RD: begin
        op         = OP_CMP_RD;
        state_next = CS_SC_EV;
      end
      CS_SC_EV: begin
        op         = OP_CMP_EV;
        state_next = stat.cmp_done ? CS_S_TAKE : CS_SC_RD;
      end
      CS_S_TAKE: begin
        op         = OP_S_TAKE;
        state_next = CS_S_RD;
      end
      CS_U_RD: begin
        op         = OP_U_RD;
        state_next = stat.u_end ? CS_W_RD : CS_U_DEC;
      end
      CS_U_DEC: begin
        op         = OP_U_DEC;
        state_next = stat.u_first ? CS_U_RD : CS_UC_RD;
      end
      CS_UC_RD: begin
        op         = OP_CMP_RD;
        state_next = CS_UC_EV;
      end
      CS_UC_EV: begin
        op         = OP_CMP_EV;
        state_next = stat.cmp_done ? CS_U_MRG : CS_UC_RD;
      end
      CS_U_MRG: begin
        op         = OP_U_MRG;
        state_next = CS_U_RD;
      end
      CS_W_RD: begin
        op         = OP_W_RD;
        state_next = stat.w_end ? CS_FIN : CS_W_COL;
      end
      CS_W_COL: begin
        op         = OP_W_COL;
        state_next = CS_W_CRD;
      end
      CS_W_CRD: begin
        op         = OP_W_CRD;
        state_next = CS_W_CODE;
      end
      CS_W_CODE: begin
        op         = OP_W_CODE;
        state_next = CS_W_WR;
      end
      CS_W_WR: begin
        op         = OP_W_WR;
        state_next = stat.r_last ? CS_W_RD : CS_W_CRD;
      end
      CS_FIN: begin
        op         = OP_FIN;
        state_next = CS_IDLE;
      end
      default: begin
        op         = OP_NOP;
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/asp_datapath.sv
// ----------------------------------------------------------------------------
// asp_datapath: memories, counters and compare logic of the compressor
// Executes one operation per cycle from the sequencer; all memories have
// registered read data.
// ----------------------------------------------------------------------------
module asp_datapath import asp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_op_t            op,
  input  asp_req_t          request,
  input  logic [TCNT_W-1:0] taxon_count,
  input  logic [SCNT_W-1:0] site_count,
  output dp_status_t        stat,
  output logic              done,
  output asp_rsp_t          result
);

  localparam int AL_AW  = ROW_W + COL_W;
  localparam int ORD_AW = COL_W + 1;

  // memories
  logic [31:0]      sm_mem  [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] sm_valid;
  logic [CHR_W-1:0] ct_mem  [ALPHABET_SIZE];
  logic [CHR_W-1:0] inv_mem [ALPHABET_SIZE];
  logic [CHR_W-1:0] al_mem  [MAX_TAXA*MAX_SITES];
  logic [CHR_W-1:0] cd_mem  [MAX_TAXA*MAX_SITES];
  logic [COL_W-1:0] ord_mem [2*MAX_SITES];
  logic [SCNT_W-1:0] wt_mem [MAX_SITES];

  logic [31:0]       sm_q;
  logic [CHR_W-1:0]  ct_q, inv_q, al_q, cd_qa, cd_qb;
  logic [COL_W-1:0]  ord_qa, ord_qb;
  logic [SCNT_W-1:0] wt_q;

  // memory port controls
  logic              sm_we, ct_we, inv_we, al_we, cd_we, ord_we, wt_we;
  logic [CHR_W-1:0]  sm_ra, ct_ra, ct_wa, ct_wd, inv_ra, inv_wa;
  logic [AL_AW-1:0]  al_ra, al_wa, cd_ra_a, cd_ra_b, cd_wa;
  logic [CHR_W-1:0]  al_wd;
  logic [ORD_AW-1:0] ord_ra_a, ord_ra_b, ord_wa;
  logic [COL_W-1:0]  ord_wd, wt_wa;
  logic [SCNT_W-1:0] wt_wd;

  // working registers
  logic [TCNT_W-1:0] t_eff;
  logic [SCNT_W-1:0] s_eff;
  logic [SCNT_W-1:0] i, u, wcnt, w, unique_total;
  logic [CHR_W-1:0]  j, nxt;
  logic [ROW_W-1:0]  r;
  logic              big, pb, lt, eq, nz, rd_ok;
  logic [31:0]       state_i;
  logic [IDX_W-1:0]  lo, mid, hi, p, q, k;
  logic [COL_W-1:0]  vp, vq, ca, cb, last, cur, col;

  logic [TCNT_W-1:0] t_cfg;
  logic [SCNT_W-1:0] s_cfg, u_m1;
  logic [IDX_W-1:0]  n12, lo_w, lo_2w, mid_n, hi_n;
  logic              p_rem, q_rem;

  assign t_cfg = (taxon_count > TCNT_W'(MAX_TAXA)) ? TCNT_W'(MAX_TAXA) : taxon_count;
  assign s_cfg = (site_count > SCNT_W'(MAX_SITES)) ? SCNT_W'(MAX_SITES) : site_count;
  assign u_m1  = u - SCNT_W'(1);

  assign n12   = IDX_W'(s_eff);
  assign lo_w  = lo + IDX_W'(w);
  assign lo_2w = lo + IDX_W'({w, 1'b0});
  assign mid_n = (lo_w < n12) ? lo_w : n12;
  assign hi_n  = (lo_2w < n12) ? lo_2w : n12;
  assign p_rem = (p < mid);
  assign q_rem = (q < hi);

  // status toward the sequencer
  always_comb begin
    stat.r_last   = (TCNT_W'(r) == t_eff - TCNT_W'(1));
    stat.chk_stop = (t_eff == '0) || (sm_q != '0) || (s_eff == '0);
    stat.idx_last = (i[CHR_W-1:0] == '1);
    stat.b_search = big && (sm_q != '0);
    stat.b_jeq    = (j == i[CHR_W-1:0]);
    stat.b_match  = (sm_q == state_i);
    stat.e_last   = stat.r_last && (i == s_eff - SCNT_W'(1));
    stat.s_wdone  = (w >= s_eff);
    stat.s_lodone = (lo >= n12);
    stat.s_both   = p_rem && q_rem;
    stat.s_none   = !p_rem && !q_rem;
    stat.cmp_done = (cd_qa != cd_qb) || stat.r_last;
    stat.u_end    = (i == s_eff);
    stat.u_first  = (u == '0);
    stat.w_end    = (i == u);
  end

  // memory addressing per operation
  always_comb begin
    sm_we    = 1'b0;
    sm_ra    = i[CHR_W-1:0];
    ct_we    = 1'b0;
    ct_ra    = al_q;
    ct_wa    = i[CHR_W-1:0];
    ct_wd    = '0;
    inv_we   = 1'b0;
    inv_ra   = cd_qa;
    inv_wa   = '0;
    al_we    = 1'b0;
    al_ra    = {request.taxon_index, request.site_index};
    al_wa    = {request.taxon_index, request.site_index};
    al_wd    = request.symbol;
    cd_we    = 1'b0;
    cd_ra_a  = {ca, r};
    cd_ra_b  = {cb, r};
    cd_wa    = {i[COL_W-1:0], r};
    ord_we   = 1'b0;
    ord_ra_a = {pb, p[COL_W-1:0]};
    ord_ra_b = {pb, q[COL_W-1:0]};
    ord_wa   = {~pb, k[COL_W-1:0]};
    ord_wd   = vp;
    wt_we    = 1'b0;
    wt_wa    = '0;
    wt_wd    = SCNT_W'(1);
    case (op)
      OP_MAP_WR: sm_we = 1'b1;
      OP_SYM_WR: al_we = 1'b1;
      OP_C_START: sm_ra = '0;
      OP_B_LD: begin
        if (!stat.b_search) begin
          ct_we  = 1'b1;
          ct_wd  = big ? '0 : sm_q[CHR_W-1:0];
          inv_we = !big && (sm_q != '0);
          inv_wa = sm_q[CHR_W-1:0];
        end
      end
      OP_B_SRD: begin
        sm_ra = j;
        ct_ra = j;
        if (stat.b_jeq) begin
          ct_we  = 1'b1;
          ct_wd  = nxt;
          inv_we = 1'b1;
          inv_wa = nxt;
        end
      end
      OP_B_SEV: begin
        if (stat.b_match) begin
          ct_we  = 1'b1;
          ct_wd  = ct_q;
          inv_we = 1'b1;
          inv_wa = ct_q;
        end
      end
      OP_E_RD: begin
        al_ra  = {r, i[COL_W-1:0]};
        ord_we = 1'b1;
        ord_wa = {1'b0, i[COL_W-1:0]};
        ord_wd = i[COL_W-1:0];
      end
      OP_E_WR: cd_we = 1'b1;
      OP_S_DEC: begin
        if (!stat.s_both && !stat.s_none) begin
          ord_we = 1'b1;
          ord_wd = p_rem ? ord_qa : ord_qb;
        end
      end
      OP_S_TAKE: begin
        ord_we = 1'b1;
        ord_wd = lt ? vq : vp;
      end
      OP_U_RD, OP_W_RD: ord_ra_a = {pb, i[COL_W-1:0]};
      OP_U_DEC: wt_we = stat.u_first;
      OP_U_MRG: begin
        wt_we = 1'b1;
        if (eq) begin
          wt_wa = u_m1[COL_W-1:0];
          wt_wd = wcnt + SCNT_W'(1);
        end else begin
          wt_wa  = u[COL_W-1:0];
          ord_we = 1'b1;
          ord_wa = {pb, u[COL_W-1:0]};
          ord_wd = cur;
        end
      end
      OP_W_CRD: cd_ra_a = {col, r};
      OP_W_WR: begin
        al_we = 1'b1;
        al_wa = {r, i[COL_W-1:0]};
        al_wd = nz ? inv_q : '0;
      end
      default: ;
    endcase
  end

  // memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[request.map_character] <= request.state_value;
    end
    sm_q <= sm_valid[sm_ra] ? sm_mem[sm_ra] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= '0;
    end else if (sm_we) begin
      sm_valid[request.map_character] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ct_we) begin
      ct_mem[ct_wa] <= ct_wd;
    end
    ct_q <= ct_mem[ct_ra];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[inv_wa] <= i[CHR_W-1:0];
    end
    inv_q <= inv_mem[inv_ra];
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      al_mem[al_wa] <= al_wd;
    end
    al_q <= al_mem[al_ra];
  end

  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[cd_wa] <= ct_q;
    end
    cd_qa <= cd_mem[cd_ra_a];
    cd_qb <= cd_mem[cd_ra_b];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_qa <= ord_mem[ord_ra_a];
    ord_qb <= ord_mem[ord_ra_b];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    wt_q <= wt_mem[request.site_index];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      unique_total <= '0;
    end else begin
      done <= 1'b0;
      case (op)
        OP_MAP_WR, OP_SYM_WR: begin
          done <= 1'b1;
        end
        OP_RD_DONE: begin
          done <= 1'b1;
        end
        OP_C_CHK: begin
          if (stat.chk_stop) begin
            done         <= 1'b1;
            unique_total <= '0;
          end
        end
        OP_FIN: begin
          done         <= 1'b1;
          unique_total <= u;
        end
        default: ;
      endcase
    end
  end

  // result payload and working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_MAP_WR, OP_SYM_WR: begin
        result <= '{STATUS_OK, unique_total, '0, '0};
      end
      OP_RD_ISSUE: begin
        rd_ok <= (SCNT_W'(request.site_index) < unique_total) &&
                 (TCNT_W'(request.taxon_index) < t_cfg);
      end
      OP_RD_DONE: begin
        result <= '{STATUS_OK, unique_total, rd_ok ? al_q : '0, rd_ok ? wt_q : '0};
      end
      OP_C_START: begin
        t_eff <= t_cfg;
        s_eff <= s_cfg;
      end
      OP_C_CHK: begin
        if (t_eff == '0) begin
          result <= '{STATUS_NO_TAXA, '0, '0, '0};
        end else if (sm_q != '0) begin
          result <= '{STATUS_MAP_ZERO, '0, '0, '0};
        end else begin
          result <= '{STATUS_OK, '0, '0, '0};
        end
        i   <= '0;
        big <= 1'b0;
        nxt <= CHR_W'(1);
      end
      OP_MX_EV: begin
        big <= big | (sm_q[31:CHR_W] != '0);
        i   <= stat.idx_last ? '0 : i + SCNT_W'(1);
      end
      OP_B_LD: begin
        state_i <= sm_q;
        j       <= '0;
      end
      OP_B_SRD: begin
        if (stat.b_jeq) begin
          nxt <= nxt + CHR_W'(1);
        end
      end
      OP_B_SEV: begin
        if (!stat.b_match) begin
          j <= j + CHR_W'(1);
        end
      end
      OP_B_ADV: begin
        i <= stat.idx_last ? '0 : i + SCNT_W'(1);
        r <= '0;
      end
      OP_E_WR: begin
        if (stat.r_last) begin
          r <= '0;
          i <= i + SCNT_W'(1);
        end else begin
          r <= r + ROW_W'(1);
        end
        w  <= SCNT_W'(1);
        pb <= 1'b0;
      end
      OP_S_PASS: begin
        i  <= '0;
        u  <= '0;
        lo <= '0;
      end
      OP_S_BLK: begin
        if (stat.s_lodone) begin
          pb <= ~pb;
          w  <= {w[SCNT_W-2:0], 1'b0};
        end else begin
          mid <= mid_n;
          hi  <= hi_n;
          p   <= lo;
          q   <= mid_n;
          k   <= lo;
        end
      end
      OP_S_DEC: begin
        vp <= ord_qa;
        vq <= ord_qb;
        ca <= ord_qb;
        cb <= ord_qa;
        r  <= '0;
        if (stat.s_none) begin
          lo <= lo_2w;
        end else if (!stat.s_both) begin
          k <= k + IDX_W'(1);
          if (p_rem) begin
            p <= p + IDX_W'(1);
          end else begin
            q <= q + IDX_W'(1);
          end
        end
      end
      OP_CMP_EV: begin
        if (cd_qa != cd_qb) begin
          lt <= (cd_qa < cd_qb);
          eq <= 1'b0;
        end else if (stat.r_last) begin
          lt <= 1'b0;
          eq <= 1'b1;
        end else begin
          r <= r + ROW_W'(1);
        end
      end
      OP_S_TAKE: begin
        k <= k + IDX_W'(1);
        if (lt) begin
          q <= q + IDX_W'(1);
        end else begin
          p <= p + IDX_W'(1);
        end
      end
      OP_U_RD: begin
        if (stat.u_end) begin
          i <= '0;
        end
      end
      OP_U_DEC: begin
        cur <= ord_qa;
        ca  <= last;
        cb  <= ord_qa;
        r   <= '0;
        if (stat.u_first) begin
          last <= ord_qa;
          wcnt <= SCNT_W'(1);
          u    <= SCNT_W'(1);
          i    <= i + SCNT_W'(1);
        end
      end
      OP_U_MRG: begin
        i <= i + SCNT_W'(1);
        if (eq) begin
          wcnt <= wcnt + SCNT_W'(1);
        end else begin
          last <= cur;
          wcnt <= SCNT_W'(1);
          u    <= u + SCNT_W'(1);
        end
      end
      OP_W_RD: r <= '0;
      OP_W_COL: col <= ord_qa;
      OP_W_CODE: nz <= (cd_qa != '0);
      OP_W_WR: begin
        if (stat.r_last) begin
          i <= i + SCNT_W'(1);
        end else begin
          r <= r + ROW_W'(1);
        end
      end
      OP_FIN: begin
        result <= '{STATUS_OK, u, '0, '0};
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/alignment_site_pattern_compressor.sv
// ----------------------------------------------------------------------------
// alignment_site_pattern_compressor: site pattern compression engine
// Loads a character map and an alignment, compresses the alignment columns
// into weighted unique patterns and serves reads of the result.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every
// transaction returns exactly one result, held on result for the single
// cycle in which done is high; the receiver cannot stall, so it must take
// it then. Map and symbol writes leave busy low and the next transaction can
// follow immediately (result in the next cycle). A read keeps busy high for
// one cycle and returns its result after the registered memory read. A
// compress runs in phases on memories with registered outputs: it scans
// the map, builds codes (renumbering states when needed), encodes the
// alignment, merge sorts the columns (column compares walk one taxon at a
// time), merges equal columns into weighted patterns and writes the unique
// patterns back. Errors finish at the check state, before the map scan.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module alignment_site_pattern_compressor import asp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  asp_req_t    request,
  // result channel
  output logic        done,
  output asp_rsp_t    result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TCNT_W-1:0] taxon_count;
  logic [SCNT_W-1:0] site_count;
  logic              cfg_wr;
  dp_op_t            op;
  dp_status_t        stat;

  // register file: two registers, word-spaced
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      taxon_count <= '0;
      site_count  <= SCNT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TAXON_COUNT: taxon_count <= pwdata[TCNT_W-1:0];
        REG_SITE_COUNT:  site_count  <= pwdata[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAXON_COUNT: prdata = 32'(taxon_count);
      REG_SITE_COUNT:  prdata = 32'(site_count);
      default:         prdata = '0;
    endcase
  end

  // sequencer: one datapath operation per cycle
  asp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .op      (op),
    .busy    (busy)
  );

  // memories, counters, column compare
  asp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .request     (request),
    .taxon_count (taxon_count),
    .site_count  (site_count),
    .stat        (stat),
    .done        (done),
    .result      (result)
  );

  // a result only follows an accepted transaction or internal work
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // a compress always occupies the block
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == CMD_COMPRESS)) |=> busy)
    else $error("compress did not raise busy");

  // a failed compress reports no unique columns
  assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_OK)) |-> (result.unique_count == '0))
    else $error("error result with nonzero unique count");

endmodule
